// ===== src/sha_pkg.sv =====
// Package: SHA-256 constants, round functions and controller command types.
package sha_pkg;

    localparam int unsigned WordW = 32;
    localparam int unsigned NumRounds = 64;

    typedef logic [WordW-1:0] word_t;

    // One-hot controller states
    typedef enum logic [5:0] {
        ST_ABSORB = 6'b000001,
        ST_PAD    = 6'b000010,
        ST_ZERO   = 6'b000100,
        ST_LEN    = 6'b001000,
        ST_COMP   = 6'b010000,
        ST_EMIT   = 6'b100000
    } state_t;

    typedef enum logic [2:0] {
        FILL_BYTE = 3'd0,
        FILL_PAD  = 3'd1,
        FILL_ZERO = 3'd2,
        FILL_LEN  = 3'd3,
        FILL_NONE = 3'd4
    } fill_t;

    // Commands from controller to datapath
    typedef struct packed {
        fill_t      fill;       // what to write into the word buffer this cycle
        logic [7:0] data;
        logic       count_len;  // add 8 to bit length
        logic       comp_start; // load working vars from hash
        logic       round_en;   // run one round
        logic       comp_done;  // add working vars into hash
        logic       reset_msg;  // return to initial values
        logic [5:0] round;
    } dp_cmd_t;

    typedef struct packed {
        logic [5:0] fill_pos;
    } dp_stat_t;

    localparam word_t InitHash [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam word_t RoundK [NumRounds] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [7:0] PadByte = 8'h80;

    function automatic word_t rotr(input word_t x, input int unsigned n);
        rotr = (x >> n) | (x << (WordW - n));
    endfunction

endpackage

// ===== src/sha256_stream_hasher.sv =====
// Top level: streaming SHA-256 hasher with byte input and digest word output.
// Each byte is written into the word buffer; the 64th byte of a block starts a
// compression (one round per cycle in the shared round unit, then the add into
// the hash), during which no transfer is taken. A finish transfer writes the
// 0x80 byte, chooses the padding path in the pad state, then fills the buffer
// one byte per cycle up to the block end, compresses one or two blocks, then
// presents the eight digest words, one per cycle while tready is high, and
// returns to the initial hash values.
module sha256_stream_hasher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // data_byte
    input  logic        s_tuser,    // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,    // digest_word[31:0], word_index[34:32], zeros
    output logic        m_tlast     // last
);
    import sha_pkg::*;

    dp_cmd_t    cmd;
    dp_stat_t   stat;
    word_t      hash_out [8];
    logic [2:0] word_index;

    sha_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .op         (s_tuser),
        .data_byte  (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .word_index (word_index),
        .cmd        (cmd),
        .stat       (stat)
    );

    sha_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .hash_out (hash_out)
    );

    assign m_tdata = {5'b0, word_index, hash_out[word_index]};
    assign m_tlast = (word_index == 3'd7);

endmodule

// ===== src/sha_datapath.sv =====
// Datapath: message buffer as a 16-word schedule window, length counter, round logic.
module sha_datapath (
    input  logic             clk,
    input  logic             rst_n,
    input  sha_pkg::dp_cmd_t cmd,
    output sha_pkg::dp_stat_t stat,
    output sha_pkg::word_t   hash_out [8]
);
    import sha_pkg::*;

    word_t       w_reg [16];
    word_t       h_reg [8];
    word_t       v_reg [8];
    logic [5:0]  pos_reg;
    logic [63:0] len_reg;

    logic [7:0] wr_byte;
    logic       wr_en;
    word_t      s0, s1, w_new;
    word_t      t1, t2, big0, big1, ch, maj;

    assign stat.fill_pos = pos_reg;
    assign hash_out = h_reg;

    always_comb
    begin
        wr_en   = 1'b1;
        wr_byte = 8'h00;
        case (cmd.fill)
            FILL_BYTE: wr_byte = cmd.data;
            FILL_PAD:  wr_byte = PadByte;
            FILL_ZERO: wr_byte = 8'h00;
            FILL_LEN:  wr_byte = len_reg[8'(63 - 8 * int'(pos_reg[2:0])) -: 8];
            default:   wr_en = 1'b0;
        endcase
    end

    // Schedule: window shifts each round, new word from w[t-16..t-2]
    always_comb
    begin
        s0    = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1    = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        w_new = s1 + w_reg[9] + s0 + w_reg[0];
        big1  = rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25);
        ch    = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t1    = v_reg[7] + big1 + ch + RoundK[cmd.round] + w_reg[0];
        big0  = rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22);
        maj   = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t2    = big0 + maj;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            w_reg[pos_reg[5:2]][8'(31 - 8 * int'(pos_reg[1:0])) -: 8] <= wr_byte;
        end
        if (cmd.comp_start)
        begin
            v_reg <= h_reg;
        end
        else if (cmd.round_en)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[15] <= w_new;
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_reg   <= InitHash;
            pos_reg <= '0;
            len_reg <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                pos_reg <= pos_reg + 6'd1;
            end
            if (cmd.count_len)
            begin
                len_reg <= len_reg + 64'd8;
            end
            if (cmd.comp_done)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    h_reg[i] <= h_reg[i] + v_reg[i];
                end
            end
            if (cmd.reset_msg)
            begin
                h_reg   <= InitHash;
                pos_reg <= '0;
                len_reg <= '0;
            end
        end
    end

endmodule

// ===== src/sha_ctrl.sv =====
// Controller: absorb, padding, compression sequencing and digest emission.
module sha_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic              op,
    input  logic [7:0]        data_byte,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [2:0]        word_index,
    output sha_pkg::dp_cmd_t  cmd,
    input  sha_pkg::dp_stat_t stat
);
    import sha_pkg::*;

    state_t     state_reg, state_next;
    logic [6:0] round_reg, round_next;  // 0..64, 64 means add into hash
    logic       fin_reg, fin_next;      // compression is part of finish
    logic       lenblk_reg, lenblk_next;
    logic [2:0] idx_reg, idx_next;

    assign s_tready   = (state_reg == ST_ABSORB);
    assign m_tvalid   = (state_reg == ST_EMIT);
    assign word_index = idx_reg;

    always_comb
    begin
        state_next     = state_reg;
        round_next     = round_reg;
        fin_next       = fin_reg;
        lenblk_next    = lenblk_reg;
        idx_next       = idx_reg;
        cmd            = '0;
        cmd.fill       = FILL_NONE;
        cmd.data       = data_byte;
        cmd.round      = round_reg[5:0];
        case (state_reg)
            ST_ABSORB:
            begin
                if (s_tvalid)
                begin
                    if (op)
                    begin
                        cmd.fill   = FILL_PAD;
                        state_next = ST_PAD;
                    end
                    else
                    begin
                        cmd.fill      = FILL_BYTE;
                        cmd.count_len = 1'b1;
                        if (stat.fill_pos == 6'd63)
                        begin
                            fin_next   = 1'b0;
                            state_next = ST_COMP;
                            round_next = '0;
                            cmd.comp_start = 1'b1;
                        end
                    end
                end
            end
            ST_PAD:
            begin
                // fill_pos is the byte after 0x80
                if (stat.fill_pos == 6'd0 || stat.fill_pos > 6'd56)
                begin
                    lenblk_next = 1'b0;
                    state_next  = ST_ZERO;
                    if (stat.fill_pos == 6'd0)
                    begin
                        // pad byte closed the block exactly
                        state_next     = ST_COMP;
                        fin_next       = 1'b1;
                        round_next     = '0;
                        cmd.comp_start = 1'b1;
                    end
                end
                else
                begin
                    lenblk_next = 1'b1;
                    state_next  = (stat.fill_pos == 6'd56) ? ST_LEN : ST_ZERO;
                end
            end
            ST_ZERO:
            begin
                cmd.fill = FILL_ZERO;
                if (lenblk_reg && stat.fill_pos == 6'd55)
                begin
                    state_next = ST_LEN;
                end
                else if (!lenblk_reg && stat.fill_pos == 6'd63)
                begin
                    state_next     = ST_COMP;
                    fin_next       = 1'b1;
                    round_next     = '0;
                    cmd.comp_start = 1'b1;
                end
            end
            ST_LEN:
            begin
                cmd.fill = FILL_LEN;
                if (stat.fill_pos == 6'd63)
                begin
                    state_next     = ST_COMP;
                    fin_next       = 1'b1;
                    round_next     = '0;
                    cmd.comp_start = 1'b1;
                end
            end
            ST_COMP:
            begin
                if (round_reg[6])
                begin
                    cmd.comp_done = 1'b1;
                    if (!fin_reg)
                    begin
                        state_next = ST_ABSORB;
                    end
                    else if (!lenblk_reg)
                    begin
                        // second block holds zeros and the length
                        lenblk_next = 1'b1;
                        state_next  = ST_ZERO;
                    end
                    else
                    begin
                        idx_next   = '0;
                        state_next = ST_EMIT;
                    end
                end
                else
                begin
                    cmd.round_en = 1'b1;
                    round_next   = round_reg + 7'd1;
                end
            end
            ST_EMIT:
            begin
                if (m_tready)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd7)
                    begin
                        cmd.reset_msg = 1'b1;
                        state_next    = ST_ABSORB;
                    end
                end
            end
            default:
            begin
                state_next = ST_ABSORB;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_ABSORB;
            round_reg  <= '0;
            fin_reg    <= 1'b0;
            lenblk_reg <= 1'b0;
            idx_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            round_reg  <= round_next;
            fin_reg    <= fin_next;
            lenblk_reg <= lenblk_next;
            idx_reg    <= idx_next;
        end
    end

endmodule
